/* rtl/fzc_pkg.sv */
// Package for the foveation zone classifier: field widths, image geometry,
// reciprocal constants for coordinate normalization, and the code enums.
// No dependencies.
package fzc_pkg;

  // Image geometry
  localparam int unsigned IMG_WIDTH  = 1024;
  localparam int unsigned IMG_HEIGHT = 576;

  // Field widths
  localparam int unsigned PIX_W    = 10;
  localparam int unsigned GAZE_W   = 17;
  localparam int unsigned RAD_W    = 18;
  localparam int unsigned SMP_W    = 8;
  localparam int unsigned ASP_W    = 16;
  localparam int unsigned ZONE_W   = 2;
  localparam int unsigned OVL_W    = 3;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 18;

  localparam int unsigned NUM_STG = 9;

  // Normalization: n = floor((p*2^17 + den) / (2*den)), den = size - 1
  localparam int unsigned DEN_X = (IMG_WIDTH > 1) ? IMG_WIDTH - 1 : 1;
  localparam int unsigned DEN_Y = (IMG_HEIGHT > 1) ? IMG_HEIGHT - 1 : 1;
  localparam int unsigned PIX_MAX = (1 << PIX_W) - 1;
  localparam int unsigned NUM_W = 28;
  localparam int unsigned RCP_SHIFT = 28;
  localparam int unsigned NX_MAX = ((PIX_MAX << 17) + DEN_X) / (2 * DEN_X);
  localparam int unsigned NY_MAX = ((PIX_MAX << 17) + DEN_Y) / (2 * DEN_Y);
  localparam int unsigned NXY_MAX = (NX_MAX > NY_MAX) ? NX_MAX : NY_MAX;
  localparam int unsigned NXY_W = $clog2(NXY_MAX + 1);
  localparam int unsigned NORM_W = (NXY_W > GAZE_W) ? NXY_W : GAZE_W;

  localparam logic [NUM_W-1:0] DIV_X = NUM_W'(2 * DEN_X);
  localparam logic [NUM_W-1:0] DIV_Y = NUM_W'(2 * DEN_Y);
  localparam logic [NUM_W-1:0] RCP_X = NUM_W'((64'd1 << RCP_SHIFT) / (2 * DEN_X));
  localparam logic [NUM_W-1:0] RCP_Y = NUM_W'((64'd1 << RCP_SHIFT) / (2 * DEN_Y));

  // Distance datapath widths
  localparam int unsigned MX_W = NORM_W + ASP_W;
  localparam int unsigned DX_W = NORM_W + 4;
  localparam int unsigned D_W  = 2 * DX_W + 1;
  localparam int unsigned HI_W = RAD_W + 1;

  // Dot radius 0.018 and ring half width 0.006, Q.16
  localparam logic [RAD_W-1:0] E_RING = RAD_W'(393);
  localparam logic [D_W-1:0]   DOT_SQ = D_W'(1180 * 1180);

  // Register reset values
  localparam logic [GAZE_W-1:0] GAZE_X_RST = GAZE_W'(32768);
  localparam logic [GAZE_W-1:0] GAZE_Y_RST = GAZE_W'(32768);
  localparam logic [RAD_W-1:0]  FOV_R_RST  = RAD_W'(11796);
  localparam logic [RAD_W-1:0]  TRN_R_RST  = RAD_W'(23593);
  localparam logic [SMP_W-1:0]  CTR_S_RST  = SMP_W'(64);
  localparam logic [SMP_W-1:0]  MID_S_RST  = SMP_W'(24);
  localparam logic [SMP_W-1:0]  PER_S_RST  = SMP_W'(8);
  localparam logic [ASP_W-1:0]  ASPECT_RST = ASP_W'(7282);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAZE_X      = 4'd0,
    REG_GAZE_Y      = 4'd1,
    REG_FOV_RADIUS  = 4'd2,
    REG_TRN_RADIUS  = 4'd3,
    REG_CTR_SAMPLES = 4'd4,
    REG_MID_SAMPLES = 4'd5,
    REG_PER_SAMPLES = 4'd6,
    REG_ASPECT      = 4'd7
  } cfg_reg_e;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_FOVEAL     = 2'd0,
    ZONE_TRANSITION = 2'd1,
    ZONE_PERIPHERY  = 2'd2
  } zone_e;

  typedef enum logic [OVL_W-1:0] {
    OVL_BACKGROUND  = 3'd0,
    OVL_TRN_FILL    = 3'd1,
    OVL_FOV_FILL    = 3'd2,
    OVL_TRN_RING    = 3'd3,
    OVL_FOV_RING    = 3'd4,
    OVL_GAZE_DOT    = 3'd5
  } ovl_e;

endpackage

/* rtl/fzc_if.sv */
// Channel interfaces of the foveation zone classifier: pixel requests,
// zone results and register writes. Depends on fzc_pkg.

interface fzc_pix_if import fzc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface fzc_res_if import fzc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ZONE_W-1:0] zone;
  logic [SMP_W-1:0]  sample_count;
  logic [OVL_W-1:0]  overlay_class;

  modport source (output valid, zone, sample_count, overlay_class, input ready);
  modport sink   (input valid, zone, sample_count, overlay_class, output ready);
endinterface

interface fzc_cfg_if import fzc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

/* rtl/foveation_zone_classifier.sv */
// Foveation zone classifier top level: nine-stage pixel pipeline and the
// register file with derived radius thresholds. Depends on fzc_pkg, fzc_if.
//
// Usage:
//   pix_i  carries one pixel request (pixel_x, pixel_y) per valid/ready beat.
//   res_o  returns one result per request, in order: zone, sample_count
//          and overlay_class.
//   cfg_i  writes register index/wdata; always ready. Write only while no
//          request is in flight. Indexes above 7 are dropped.
//   Each request passes through the nine register stages (normalize by
//   reciprocal multiply and correction, gaze offset, aspect scale,
//   rounding, squares, sum, compare). Throughput: one pixel per cycle
//   while res_o.ready is high.
//   Radius thresholds are squared in registers in the cycle after the
//   register file changes, well ahead of any request that follows a write.
//   Reset: all stages empty, registers return to their default values.
//   Stall: a stage holds while the next one is full and stalled; bubbles
//   are squeezed out, so pix_i.ready drops only once all nine stages are
//   full and res_o.ready is low.
module foveation_zone_classifier import fzc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fzc_pix_if.sink    pix_i,
  fzc_res_if.source  res_o,
  fzc_cfg_if.sink    cfg_i
);

  // ---------------------------------------------------------------- registers
  logic [GAZE_W-1:0] gaze_x_q, gaze_y_q;
  logic [RAD_W-1:0]  fov_r_q, trn_r_q;
  logic [SMP_W-1:0]  ctr_s_q, mid_s_q, per_s_q;
  logic [ASP_W-1:0]  aspect_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gaze_x_q <= GAZE_X_RST;
      gaze_y_q <= GAZE_Y_RST;
      fov_r_q  <= FOV_R_RST;
      trn_r_q  <= TRN_R_RST;
      ctr_s_q  <= CTR_S_RST;
      mid_s_q  <= MID_S_RST;
      per_s_q  <= PER_S_RST;
      aspect_q <= ASPECT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_GAZE_X:      gaze_x_q <= cfg_i.wdata[GAZE_W-1:0];
        REG_GAZE_Y:      gaze_y_q <= cfg_i.wdata[GAZE_W-1:0];
        REG_FOV_RADIUS:  fov_r_q  <= cfg_i.wdata[RAD_W-1:0];
        REG_TRN_RADIUS:  trn_r_q  <= cfg_i.wdata[RAD_W-1:0];
        REG_CTR_SAMPLES: ctr_s_q  <= cfg_i.wdata[SMP_W-1:0];
        REG_MID_SAMPLES: mid_s_q  <= cfg_i.wdata[SMP_W-1:0];
        REG_PER_SAMPLES: per_s_q  <= cfg_i.wdata[SMP_W-1:0];
        REG_ASPECT:      aspect_q <= cfg_i.wdata[ASP_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived thresholds: plain squares plus ring bounds (r +/- E_RING)^2
  logic [2*RAD_W-1:0] fov_sq_q, trn_sq_q, fov_lo_sq_q, trn_lo_sq_q;
  logic [2*HI_W-1:0]  fov_hi_sq_q, trn_hi_sq_q;
  logic               fov_lo_en_q, trn_lo_en_q;
  logic [HI_W-1:0]    fov_hi, trn_hi;
  logic [RAD_W-1:0]   fov_lo, trn_lo;

  assign fov_hi = HI_W'(fov_r_q) + HI_W'(E_RING);
  assign trn_hi = HI_W'(trn_r_q) + HI_W'(E_RING);
  assign fov_lo = fov_r_q - E_RING;
  assign trn_lo = trn_r_q - E_RING;

  always_ff @(posedge clk_i) begin
    fov_sq_q    <= fov_r_q * fov_r_q;
    trn_sq_q    <= trn_r_q * trn_r_q;
    fov_hi_sq_q <= fov_hi * fov_hi;
    trn_hi_sq_q <= trn_hi * trn_hi;
    fov_lo_sq_q <= fov_lo * fov_lo;
    trn_lo_sq_q <= trn_lo * trn_lo;
    fov_lo_en_q <= (fov_r_q >= E_RING);
    trn_lo_en_q <= (trn_r_q >= E_RING);
  end

  // ---------------------------------------------------------- pipeline control
  logic [NUM_STG-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NUM_STG-1] = !vld_q[NUM_STG-1] || res_o.ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = pix_i.valid;
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pix_i.ready = en[0];

  // ---------------------------------------------------------------- datapath
  // Stage 0: numerator and reciprocal product
  logic [NUM_W-1:0]   num_x, num_y;
  logic [NUM_W-1:0]   s0_num_x_q, s0_num_y_q;
  logic [2*NUM_W-1:0] s0_prd_x_q, s0_prd_y_q;

  assign num_x = NUM_W'({pix_i.pixel_x, 17'b0}) + NUM_W'(DEN_X);
  assign num_y = NUM_W'({pix_i.pixel_y, 17'b0}) + NUM_W'(DEN_Y);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_num_x_q <= num_x;
      s0_num_y_q <= num_y;
      s0_prd_x_q <= num_x * RCP_X;
      s0_prd_y_q <= num_y * RCP_Y;
    end
  end

  // Stage 1: quotient estimate (low by at most one) and its back product
  logic [NORM_W-1:0] q0_x, q0_y;
  logic [NORM_W-1:0] s1_q_x_q, s1_q_y_q;
  logic [NUM_W-1:0]  s1_num_x_q, s1_num_y_q, s1_qd_x_q, s1_qd_y_q;

  assign q0_x = s0_prd_x_q[RCP_SHIFT +: NORM_W];
  assign q0_y = s0_prd_y_q[RCP_SHIFT +: NORM_W];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_q_x_q   <= q0_x;
      s1_q_y_q   <= q0_y;
      s1_num_x_q <= s0_num_x_q;
      s1_num_y_q <= s0_num_y_q;
      s1_qd_x_q  <= NUM_W'(NUM_W'(q0_x) * DIV_X);
      s1_qd_y_q  <= NUM_W'(NUM_W'(q0_y) * DIV_Y);
    end
  end

  // Stage 2: remainder correction gives the normalized coordinate
  logic [NUM_W-1:0]  rem_x, rem_y;
  logic [NORM_W-1:0] s2_nx_q, s2_ny_q;

  assign rem_x = s1_num_x_q - s1_qd_x_q;
  assign rem_y = s1_num_y_q - s1_qd_y_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_nx_q <= s1_q_x_q + NORM_W'(rem_x >= DIV_X);
      s2_ny_q <= s1_q_y_q + NORM_W'(rem_y >= DIV_Y);
    end
  end

  // Stage 3: offsets from the gaze point
  logic [NORM_W-1:0] gx, gy, s3_ax_q, s3_ay_q;

  assign gx = NORM_W'(gaze_x_q);
  assign gy = NORM_W'(gaze_y_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_ax_q <= (s2_nx_q >= gx) ? s2_nx_q - gx : gx - s2_nx_q;
      s3_ay_q <= (s2_ny_q >= gy) ? s2_ny_q - gy : gy - s2_ny_q;
    end
  end

  // Stage 4: aspect scaling
  logic [MX_W-1:0]   s4_mx_q;
  logic [NORM_W-1:0] s4_ay_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_mx_q <= s3_ax_q * aspect_q;
      s4_ay_q <= s3_ay_q;
    end
  end

  // Stage 5: round the Q.16 x Q4.12 product back to Q.16
  logic [MX_W-1:0]   mx_rnd;
  logic [DX_W-1:0]   s5_dx_q;
  logic [NORM_W-1:0] s5_ay_q;

  assign mx_rnd = s4_mx_q + MX_W'(2048);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_dx_q <= mx_rnd[12 +: DX_W];
      s5_ay_q <= s4_ay_q;
    end
  end

  // Stage 6: squares
  logic [2*DX_W-1:0]   s6_sqx_q;
  logic [2*NORM_W-1:0] s6_sqy_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_sqx_q <= s5_dx_q * s5_dx_q;
      s6_sqy_q <= s5_ay_q * s5_ay_q;
    end
  end

  // Stage 7: squared distance
  logic [D_W-1:0] s7_d2_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_d2_q <= D_W'(s6_sqx_q) + D_W'(s6_sqy_q);
    end
  end

  // Stage 8: zone and overlay decision, output register
  zone_e            zone_c;
  ovl_e             ovl_c;
  logic [SMP_W-1:0] smp_c;
  logic             fov_ring, trn_ring;

  assign fov_ring = (s7_d2_q < D_W'(fov_hi_sq_q)) &&
                    (!fov_lo_en_q || (s7_d2_q > D_W'(fov_lo_sq_q)));
  assign trn_ring = (s7_d2_q < D_W'(trn_hi_sq_q)) &&
                    (!trn_lo_en_q || (s7_d2_q > D_W'(trn_lo_sq_q)));

  always_comb begin
    if (s7_d2_q <= D_W'(fov_sq_q)) begin
      zone_c = ZONE_FOVEAL;
      smp_c  = ctr_s_q;
      ovl_c  = OVL_FOV_FILL;
    end else if (s7_d2_q <= D_W'(trn_sq_q)) begin
      zone_c = ZONE_TRANSITION;
      smp_c  = mid_s_q;
      ovl_c  = OVL_TRN_FILL;
    end else begin
      zone_c = ZONE_PERIPHERY;
      smp_c  = per_s_q;
      ovl_c  = OVL_BACKGROUND;
    end
    if (s7_d2_q < DOT_SQ) begin
      ovl_c = OVL_GAZE_DOT;
    end else if (fov_ring) begin
      ovl_c = OVL_FOV_RING;
    end else if (trn_ring) begin
      ovl_c = OVL_TRN_RING;
    end
  end

  zone_e            out_zone_q;
  ovl_e             out_ovl_q;
  logic [SMP_W-1:0] out_smp_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      out_zone_q <= zone_c;
      out_ovl_q  <= ovl_c;
      out_smp_q  <= smp_c;
    end
  end

  assign res_o.valid         = vld_q[NUM_STG-1];
  assign res_o.zone          = out_zone_q;
  assign res_o.sample_count  = out_smp_q;
  assign res_o.overlay_class = out_ovl_q;

  // -------------------------------------------------------------- assertions
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> vld_q[0])
    else $error("accepted request did not enter stage 0");

  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (&vld_q))
    else $error("input blocked while a pipeline stage is empty");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[7] && !en[7]) |=> (vld_q[7] && $stable(s7_d2_q)))
    else $error("stalled distance stage lost or changed its item");

  a_norm_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> ((s2_nx_q <= NORM_W'(NX_MAX)) && (s2_ny_q <= NORM_W'(NY_MAX))))
    else $error("normalized coordinate above its maximum");

  a_fill_zone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |->
      ((out_ovl_q != OVL_FOV_FILL || out_zone_q == ZONE_FOVEAL) &&
       (out_ovl_q != OVL_TRN_FILL || out_zone_q == ZONE_TRANSITION) &&
       (out_ovl_q != OVL_BACKGROUND || out_zone_q == ZONE_PERIPHERY)))
    else $error("fill overlay class disagrees with zone");

endmodule

/* tb/foveation_zone_classifier_tb.sv */
// Self-checking bench for foveation_zone_classifier: random pixel requests with
// random stalls on both channels, checked against a zone/overlay predictor.
// Depends on fzc_pkg, fzc_if and the RTL top level.
`timescale 1ns / 100ps

module foveation_zone_classifier_tb;
  import fzc_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int NUM_REGS     = int'(REG_ASPECT) + 1;
  localparam int REG_UNUSED   = NUM_REGS;
  localparam int PHASE_ITEMS  = 140;
  localparam int HOLD_CYCLES  = 40;
  localparam int STALL_LIMIT  = 1000;
  localparam int NEAR_SPAN    = 64;
  localparam longint unsigned DOT_R     = 1180;
  localparam longint unsigned RING_HALF = 393;
  localparam longint unsigned ASPECT_UNITY = 4096;

  // register setting kinds
  localparam int SET_TYPICAL     = 0;
  localparam int SET_FULL_RANDOM = 1;
  localparam int SET_ZERO_EDGE   = 2;
  localparam int SET_MAX_EDGE    = 3;
  localparam int SET_TINY_RADII  = 4;
  localparam int SET_UNIT_GAZE   = 5;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    zone_e            zone;
    logic [SMP_W-1:0] samples;
    ovl_e             ovl;
  } zone_result_t;

  class zone_result_board;
    logic [GAZE_W-1:0] gaze_x, gaze_y;
    logic [RAD_W-1:0]  fov_r, trn_r;
    logic [SMP_W-1:0]  ctr_s, mid_s, per_s;
    logic [ASP_W-1:0]  aspect;
    zone_result_t      expected_zones[$];
    int                errors;
    int                checked;
    int                zone_seen[3];
    int                ovl_seen[6];

    function new();
      gaze_x = GAZE_X_RST;
      gaze_y = GAZE_Y_RST;
      fov_r  = FOV_R_RST;
      trn_r  = TRN_R_RST;
      ctr_s  = CTR_S_RST;
      mid_s  = MID_S_RST;
      per_s  = PER_S_RST;
      aspect = ASPECT_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_GAZE_X:      gaze_x = data[GAZE_W-1:0];
        REG_GAZE_Y:      gaze_y = data[GAZE_W-1:0];
        REG_FOV_RADIUS:  fov_r  = data[RAD_W-1:0];
        REG_TRN_RADIUS:  trn_r  = data[RAD_W-1:0];
        REG_CTR_SAMPLES: ctr_s  = data[SMP_W-1:0];
        REG_MID_SAMPLES: mid_s  = data[SMP_W-1:0];
        REG_PER_SAMPLES: per_s  = data[SMP_W-1:0];
        REG_ASPECT:      aspect = data[ASP_W-1:0];
        default: ;
      endcase
    endfunction

    // p / (size-1) in Q.16, rounded half up
    function longint unsigned norm(longint unsigned p, longint unsigned size);
      longint unsigned den;
      den = (size > 1) ? size - 1 : 1;
      return ((p << 17) + den) / (2 * den);
    endfunction

    function bit on_ring(longint unsigned d2, longint unsigned r);
      if (!(d2 < (r + RING_HALF) * (r + RING_HALF)))
        return 1'b0;
      if (r >= RING_HALF)
        return d2 > (r - RING_HALF) * (r - RING_HALF);
      return 1'b1;
    endfunction

    function zone_result_t classify_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      zone_result_t    r;
      longint unsigned nx, ny, ax, ay, dx, d2, fr, tr;
      nx = norm(px, IMG_WIDTH);
      ny = norm(py, IMG_HEIGHT);
      ax = (nx >= gaze_x) ? nx - gaze_x : gaze_x - nx;
      ay = (ny >= gaze_y) ? ny - gaze_y : gaze_y - ny;
      dx = (ax * aspect + 2048) >> 12;
      d2 = dx * dx + ay * ay;
      fr = fov_r;
      tr = trn_r;
      r.pixel_x = px;
      r.pixel_y = py;
      if (d2 <= fr * fr) begin
        r.zone = ZONE_FOVEAL;     r.samples = ctr_s; r.ovl = OVL_FOV_FILL;
      end else if (d2 <= tr * tr) begin
        r.zone = ZONE_TRANSITION; r.samples = mid_s; r.ovl = OVL_TRN_FILL;
      end else begin
        r.zone = ZONE_PERIPHERY;  r.samples = per_s; r.ovl = OVL_BACKGROUND;
      end
      if (d2 < DOT_R * DOT_R)
        r.ovl = OVL_GAZE_DOT;
      else if (on_ring(d2, fr))
        r.ovl = OVL_FOV_RING;
      else if (on_ring(d2, tr))
        r.ovl = OVL_TRN_RING;
      return r;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      expected_zones.push_back(classify_pixel(px, py));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50)
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [ZONE_W-1:0] zone, logic [SMP_W-1:0] samples,
                      logic [OVL_W-1:0] ovl);
      zone_result_t want;
      if (expected_zones.size() == 0) begin
        report($sformatf("unexpected result zone %0d samples %0d overlay %0d",
                         zone, samples, ovl));
        return;
      end
      want = expected_zones.pop_front();
      checked++;
      zone_seen[want.zone]++;
      ovl_seen[want.ovl]++;
      if (zone !== want.zone)
        report($sformatf("pixel (%0d,%0d) zone %0d, want %0d",
                         want.pixel_x, want.pixel_y, zone, want.zone));
      if (samples !== want.samples)
        report($sformatf("pixel (%0d,%0d) sample_count %0d, want %0d",
                         want.pixel_x, want.pixel_y, samples, want.samples));
      if (ovl !== want.ovl)
        report($sformatf("pixel (%0d,%0d) overlay_class %0d, want %0d",
                         want.pixel_x, want.pixel_y, ovl, want.ovl));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fzc_pix_if pix ();
  fzc_res_if res ();
  fzc_cfg_if cfg ();

  foveation_zone_classifier dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  zone_result_board      sb;
  logic [CFG_DAT_W-1:0]  next_regs [NUM_REGS];
  bit                    steady_flow;
  bit                    hold_pending;
  int                    idle_cycles;
  int                    settings_loaded;
  int                    phase_plan [10] = '{SET_TYPICAL, SET_ZERO_EDGE, SET_TYPICAL,
                                             SET_MAX_EDGE, SET_FULL_RANDOM, SET_TINY_RADII,
                                             SET_TYPICAL, SET_UNIT_GAZE, SET_FULL_RANDOM,
                                             SET_TYPICAL};

  function automatic int draw_gap();
    return steady_flow ? 0 : int'($urandom_range(0, 3));
  endfunction

  // no request accepted on any channel for too long
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_pixel(int px, int py);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= PIX_W'(px);
    pix.pixel_y <= PIX_W'(py);
    do @(posedge clk); while (pix.ready !== 1'b1);
    sb.note_pixel(PIX_W'(px), PIX_W'(py));
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (sb.expected_zones.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // all registers, then one write to an unmapped index that must be dropped
  task automatic load_setting();
    for (int i = 0; i < NUM_REGS; i++)
      cfg_write(CFG_IDX_W'(i), next_regs[i]);
    cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED, (1 << CFG_IDX_W) - 1)),
              CFG_DAT_W'($urandom));
    cfg.valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic choose_setting(int kind);
    int unsigned fr;
    case (kind)
      SET_TYPICAL: begin
        fr = $urandom_range(1500, 9000);
        next_regs[REG_GAZE_X]      = CFG_DAT_W'($urandom_range(0, 65536));
        next_regs[REG_GAZE_Y]      = CFG_DAT_W'($urandom_range(0, 65536));
        next_regs[REG_FOV_RADIUS]  = CFG_DAT_W'(fr);
        next_regs[REG_TRN_RADIUS]  = CFG_DAT_W'(fr + $urandom_range(500, 9000));
        next_regs[REG_CTR_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_MID_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_PER_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_ASPECT]      = CFG_DAT_W'($urandom_range(4096, 9000));
      end
      SET_ZERO_EDGE: begin
        next_regs[REG_GAZE_X]      = '0;
        next_regs[REG_GAZE_Y]      = '0;
        next_regs[REG_FOV_RADIUS]  = '0;
        next_regs[REG_TRN_RADIUS]  = CFG_DAT_W'((1 << RAD_W) - 1);
        next_regs[REG_CTR_SAMPLES] = CFG_DAT_W'((1 << SMP_W) - 1);
        next_regs[REG_MID_SAMPLES] = '0;
        next_regs[REG_PER_SAMPLES] = CFG_DAT_W'((1 << SMP_W) - 1);
        next_regs[REG_ASPECT]      = CFG_DAT_W'((1 << ASP_W) - 1);
      end
      SET_MAX_EDGE: begin
        // gaze written with bit 17 set: masked to the 17-bit maximum
        next_regs[REG_GAZE_X]      = '1;
        next_regs[REG_GAZE_Y]      = '1;
        next_regs[REG_FOV_RADIUS]  = '1;
        next_regs[REG_TRN_RADIUS]  = '0;
        next_regs[REG_CTR_SAMPLES] = '0;
        next_regs[REG_MID_SAMPLES] = CFG_DAT_W'((1 << SMP_W) - 1);
        next_regs[REG_PER_SAMPLES] = '0;
        next_regs[REG_ASPECT]      = '0;
      end
      SET_TINY_RADII: begin
        next_regs[REG_GAZE_X]      = CFG_DAT_W'($urandom_range(0, 65536));
        next_regs[REG_GAZE_Y]      = CFG_DAT_W'($urandom_range(0, 65536));
        next_regs[REG_FOV_RADIUS]  = CFG_DAT_W'($urandom_range(0, RING_HALF - 1));
        next_regs[REG_TRN_RADIUS]  = CFG_DAT_W'($urandom_range(0, 2 * RING_HALF));
        next_regs[REG_CTR_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_MID_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_PER_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_ASPECT]      = CFG_DAT_W'($urandom_range(2048, 8192));
      end
      SET_UNIT_GAZE: begin
        next_regs[REG_GAZE_X]      = CFG_DAT_W'(65536);
        next_regs[REG_GAZE_Y]      = CFG_DAT_W'(65536);
        next_regs[REG_FOV_RADIUS]  = CFG_DAT_W'($urandom_range(8000, 30000));
        next_regs[REG_TRN_RADIUS]  = CFG_DAT_W'($urandom_range(20000, 60000));
        next_regs[REG_CTR_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_MID_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_PER_SAMPLES] = CFG_DAT_W'($urandom);
        next_regs[REG_ASPECT]      = CFG_DAT_W'($urandom_range(3000, 12000));
      end
      default: begin
        for (int i = 0; i < NUM_REGS; i++)
          next_regs[i] = CFG_DAT_W'($urandom);
      end
    endcase
  endtask

  // half near the gaze point, the rest across the image and beyond its last row
  task automatic send_random_pixel();
    int roll, px, py;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      px = int'((longint'(sb.gaze_x) * (IMG_WIDTH - 1)) >> 16)
           + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
      py = int'((longint'(sb.gaze_y) * (IMG_HEIGHT - 1)) >> 16)
           + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
      px = (px < 0) ? 0 : (px > PIX_MAX) ? PIX_MAX : px;
      py = (py < 0) ? 0 : (py > PIX_MAX) ? PIX_MAX : py;
    end else if (roll < 85) begin
      px = $urandom_range(0, IMG_WIDTH - 1);
      py = $urandom_range(0, IMG_HEIGHT - 1);
    end else begin
      px = $urandom_range(0, PIX_MAX);
      py = $urandom_range(0, PIX_MAX);
    end
    send_pixel(px, py);
  endtask

  initial begin : result_sink
    int stall;
    res.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (res.valid !== 1'b1);
      sb.check_result(res.zone, res.sample_count, res.overlay_class);
    end
  end

  initial begin : stimulus
    longint unsigned gx, gy, r_in, r_out;
    sb = new();
    rst_n       <= 1'b0;
    pix.valid   <= 1'b0;
    pix.pixel_x <= '0;
    pix.pixel_y <= '0;
    cfg.valid   <= 1'b0;
    cfg.index   <= '0;
    cfg.wdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: image corners, rows past the image, the default gaze
    send_pixel(0, 0);
    send_pixel(PIX_MAX, 0);
    send_pixel(0, IMG_HEIGHT - 1);
    send_pixel(PIX_MAX, IMG_HEIGHT - 1);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(IMG_WIDTH / 2 - 1, IMG_HEIGHT / 2 - 1);
    send_pixel(IMG_WIDTH / 2, IMG_HEIGHT / 2);
    send_pixel(600, IMG_HEIGHT);
    drain();

    // gaze on a pixel, unit aspect: radii land exactly on pixels of its row,
    // so the inclusive zone boundaries are hit
    gx    = sb.norm(512, IMG_WIDTH);
    gy    = sb.norm(288, IMG_HEIGHT);
    r_in  = sb.norm(532, IMG_WIDTH) - gx;
    r_out = sb.norm(572, IMG_WIDTH) - gx;
    next_regs[REG_GAZE_X]      = CFG_DAT_W'(gx);
    next_regs[REG_GAZE_Y]      = CFG_DAT_W'(gy);
    next_regs[REG_FOV_RADIUS]  = CFG_DAT_W'(r_in);
    next_regs[REG_TRN_RADIUS]  = CFG_DAT_W'(r_out);
    next_regs[REG_CTR_SAMPLES] = CFG_DAT_W'(10);
    next_regs[REG_MID_SAMPLES] = CFG_DAT_W'(20);
    next_regs[REG_PER_SAMPLES] = CFG_DAT_W'(30);
    next_regs[REG_ASPECT]      = CFG_DAT_W'(ASPECT_UNITY);
    load_setting();
    send_pixel(512, 288);
    for (int k = 531; k <= 533; k++) send_pixel(k, 288);
    for (int k = 571; k <= 573; k++) send_pixel(k, 288);
    drain();

    // same pixels sitting exactly on the open ends of both rings
    next_regs[REG_FOV_RADIUS] = CFG_DAT_W'(r_in - RING_HALF);
    next_regs[REG_TRN_RADIUS] = CFG_DAT_W'(r_out + RING_HALF);
    load_setting();
    send_pixel(531, 288);
    send_pixel(532, 288);
    send_pixel(572, 288);
    send_pixel(573, 288);
    drain();

    foreach (phase_plan[p]) begin
      choose_setting(phase_plan[p]);
      load_setting();
      steady_flow  = (p == 3 || p == 7);
      hold_pending = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_random_pixel();
      drain();
    end
    steady_flow = 1'b0;
    repeat (16) @(posedge clk);

    $display("checked %0d pixel results over %0d register settings (edge radii, gaze past 1.0,",
             sb.checked, settings_loaded);
    $display("rows past the image); zones f/t/p %0d/%0d/%0d, overlays bg..dot %0d %0d %0d %0d %0d %0d",
             sb.zone_seen[0], sb.zone_seen[1], sb.zone_seen[2], sb.ovl_seen[0], sb.ovl_seen[1],
             sb.ovl_seen[2], sb.ovl_seen[3], sb.ovl_seen[4], sb.ovl_seen[5]);
    if (sb.errors == 0 && sb.expected_zones.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
